>>> design/multi_receiver_lap_time_recorder_assert.svh
`ifndef MULTI_RECEIVER_LAP_TIME_RECORDER_ASSERT_SVH
`define MULTI_RECEIVER_LAP_TIME_RECORDER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LAPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LAPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lapt_pkg.sv
`default_nettype none

package lapt_pkg;

  localparam int unsigned RECEIVERS_DEF = 8;
  localparam int unsigned LAPS_DEF      = 64;

  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned RX_W       = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned LAP_IDX_W  = 6;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ACTIVE_W   = 4;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd6;
  localparam logic                SOUND_RESET  = 1'b1;
  localparam logic [TIME_W-1:0]   TIME_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START      = 3'd0,
    OP_CROSS      = 3'd1,
    OP_READ_ABS   = 3'd2,
    OP_READ_DUR   = 3'd3,
    OP_READ_SINCE = 3'd4
  } op_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE   = 2'd0,
    CLS_BEST   = 2'd1,
    CLS_FASTER = 2'd2,
    CLS_SLOWER = 2'd3
  } lap_class_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_RX = 1'b0,
    CFG_SOUND     = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SWEEP,
    S_CALC
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic init_start;
    logic sel_b;
    logic cap_a;
    logic sweep_wr;
    logic clear_wr;
    logic calc;
  } lapt_cmd_t;

  typedef struct packed {
    logic is_start;
    logic need_mem;
    logic sweep_done;
    logic clear_done;
  } lapt_sts_t;

endpackage

`default_nettype wire

>>> design/lapt_ram.sv
`default_nettype none

module lapt_ram import lapt_pkg::*; #(
  parameter int unsigned WIDTH = TIME_W,
  parameter int unsigned DEPTH = RECEIVERS_DEF * LAPS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/lapt_ctrl.sv
`default_nettype none

module lapt_ctrl import lapt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire lapt_sts_t sts_i,
  output lapt_cmd_t      cmd_o,
  output logic           busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_start) begin
          state_d = S_SWEEP;
        end else if (sts_i.need_mem) begin
          state_d = S_READ;
        end else begin
          state_d = S_CALC;
        end
      end
      S_READ: begin
        state_d = S_CALC;
      end
      S_SWEEP: begin
        if (sts_i.sweep_done) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
      end
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      S_DECODE: begin
        cmd_o.init_start = sts_i.is_start;
      end
      S_READ: begin
        cmd_o.cap_a = 1'b1;
        cmd_o.sel_b = 1'b1;
      end
      S_SWEEP: begin
        cmd_o.sweep_wr = !sts_i.sweep_done;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/lapt_dp.sv
`default_nettype none

`include "multi_receiver_lap_time_recorder_assert.svh"

module lapt_dp import lapt_pkg::*; #(
  parameter int unsigned RECEIVERS = RECEIVERS_DEF,
  parameter int unsigned LAPS      = LAPS_DEF,
  localparam int unsigned AW = $clog2(RECEIVERS * LAPS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [RX_W-1:0]       receiver_i,
  input  wire logic [TIME_W-1:0]     time_ms_i,
  input  wire logic [LAP_IDX_W-1:0]  lap_index_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire lapt_cmd_t             cmd_i,
  output lapt_sts_t                  sts_o,
  output logic                       ram_we_o,
  output logic      [AW-1:0]         ram_waddr_o,
  output logic      [TIME_W-1:0]     ram_wdata_o,
  output logic      [AW-1:0]         ram_raddr_o,
  input  wire logic [TIME_W-1:0]     ram_rdata_i,
  output logic                       result_valid_o,
  output logic      [COUNT_W-1:0]    lap_count_o,
  output logic      [TIME_W-1:0]     lap_ms_o,
  output logic      [CLASS_W-1:0]    lap_class_o,
  output logic      [TIME_W-1:0]     best_ms_o,
  output logic      [STATUS_W-1:0]   status_o
);

  localparam int unsigned DEPTH = RECEIVERS * LAPS;
  localparam int unsigned RXW   = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;
  localparam int unsigned CW    = $clog2(LAPS);
  localparam int unsigned NW    = $clog2(RECEIVERS + 1);

  logic [OPCODE_W-1:0]  op_q;
  logic [RX_W-1:0]      rx_q;
  logic [TIME_W-1:0]    t_q;
  logic [LAP_IDX_W-1:0] lap_q;
  logic [ACTIVE_W-1:0]  active_q;
  logic                 sound_q;
  logic [TIME_W-1:0]    race_q;
  logic [TIME_W-1:0]    best_q, best_d;
  logic [CW-1:0]        counts_q [RECEIVERS];
  logic [TIME_W-1:0]    a_q;
  logic [NW-1:0]        swp_q;
  logic [AW-1:0]        clr_q;

  logic                 valid_q;
  logic [COUNT_W-1:0]   lap_count_q;
  logic [TIME_W-1:0]    lap_ms_q, ms_d;
  lap_class_e           lap_class_q, cls_d;
  status_e              status_q, st_d;

  logic          rx_ok, lap_ok, full, is_cross, is_read, cross_ok, read_ok, sweep_go;
  logic [RXW-1:0] rx_idx;
  logic [CW-1:0]  cnt, new_cnt, lap_idx, idx_a, idx_b;
  logic [AW-1:0]  base;
  logic [NW-1:0]  n_act;
  logic [TIME_W-1:0] cur, prev;

  assign rx_ok    = 32'(rx_q) < RECEIVERS;
  assign rx_idx   = RXW'(rx_q);
  assign cnt      = rx_ok ? counts_q[rx_idx] : '0;
  assign lap_ok   = 32'(lap_q) < LAPS;
  assign lap_idx  = CW'(lap_q);
  assign full     = (32'(cnt) + 32'd1) >= LAPS;
  assign is_cross = op_q == OP_CROSS;
  assign is_read  = (op_q == OP_READ_ABS) || (op_q == OP_READ_DUR) ||
                    (op_q == OP_READ_SINCE);
  assign cross_ok = rx_ok && is_cross && !full;
  assign read_ok  = rx_ok && is_read && lap_ok;

  assign idx_a = is_cross ? cnt : lap_idx;
  assign idx_b = is_cross ? ((cnt == '0) ? cnt : cnt - CW'(1))
                          : ((lap_idx == '0) ? lap_idx : lap_idx - CW'(1));
  assign base  = rx_ok ? AW'(AW'(rx_idx) * AW'(LAPS)) : '0;

  assign n_act    = (32'(active_q) > RECEIVERS) ? NW'(RECEIVERS) : NW'(active_q);
  assign sweep_go = swp_q < n_act;

  assign sts_o.is_start   = op_q == OP_START;
  assign sts_o.need_mem   = cross_ok || read_ok;
  assign sts_o.sweep_done = !sweep_go;
  assign sts_o.clear_done = clr_q == AW'(DEPTH - 1);

  assign ram_raddr_o = base + (cmd_i.sel_b ? AW'(idx_b) : AW'(idx_a));

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = clr_q;
    ram_wdata_o = '0;
    if (cmd_i.clear_wr) begin
      ram_we_o = 1'b1;
    end else if (cmd_i.sweep_wr && sweep_go) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = AW'(AW'(swp_q[RXW-1:0]) * AW'(LAPS));
      ram_wdata_o = t_q;
    end else if (cmd_i.calc && cross_ok) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = base + AW'(cnt) + AW'(1);
      ram_wdata_o = t_q;
    end
  end

  assign cur  = t_q - a_q;
  assign prev = (cnt == '0) ? cur : a_q - ram_rdata_i;

  always_comb begin
    ms_d    = '0;
    cls_d   = CLS_NONE;
    st_d    = ST_OK;
    best_d  = best_q;
    new_cnt = cnt;
    if (is_cross && rx_ok) begin
      if (full) begin
        st_d = ST_FULL;
      end else begin
        ms_d    = cur;
        new_cnt = cnt + CW'(1);
        if (cur < best_q) begin
          best_d = cur;
        end
        if (sound_q) begin
          if (cur <= best_q) begin
            cls_d = CLS_BEST;
          end else if (cur < prev) begin
            cls_d = CLS_FASTER;
          end else begin
            cls_d = CLS_SLOWER;
          end
        end
      end
    end else if (is_read && rx_ok) begin
      if (!lap_ok) begin
        st_d = ST_BAD_INDEX;
      end else begin
        case (op_e'(op_q))
          OP_READ_ABS: begin
            ms_d = a_q;
          end
          OP_READ_DUR: begin
            if (lap_q == '0) begin
              ms_d = '0;
            end else if (lap_q == LAP_IDX_W'(1)) begin
              ms_d = a_q - race_q;
            end else begin
              ms_d = a_q - ram_rdata_i;
            end
          end
          OP_READ_SINCE: begin
            ms_d = a_q - race_q;
          end
          default: begin
            ms_d = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      rx_q  <= receiver_i;
      t_q   <= time_ms_i;
      lap_q <= lap_index_i;
    end
    if (cmd_i.cap_a) begin
      a_q <= ram_rdata_i;
    end
    if (cmd_i.calc) begin
      lap_count_q <= COUNT_W'(new_cnt);
      lap_ms_q    <= ms_d;
      lap_class_q <= cls_d;
      status_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
      sound_q  <= SOUND_RESET;
      race_q   <= '0;
      best_q   <= TIME_ALL_ONES;
      swp_q    <= '0;
      clr_q    <= '0;
      valid_q  <= 1'b0;
      for (int i = 0; i < RECEIVERS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      valid_q <= cmd_i.calc;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ACTIVE_RX: active_q <= cfg_data_i[ACTIVE_W-1:0];
          CFG_SOUND:     sound_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.init_start) begin
        race_q <= t_q;
        swp_q  <= '0;
      end else if (cmd_i.sweep_wr && sweep_go) begin
        swp_q <= swp_q + NW'(1);
      end
      if (cmd_i.calc) begin
        best_q <= best_d;
      end
      for (int i = 0; i < RECEIVERS; i++) begin
        if (cmd_i.init_start && (i < int'(n_act))) begin
          counts_q[i] <= '0;
        end else if (cmd_i.calc && cross_ok && (RXW'(i) == rx_idx)) begin
          counts_q[i] <= new_cnt;
        end
      end
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = valid_q;
  assign lap_count_o    = lap_count_q;
  assign lap_ms_o       = lap_ms_q;
  assign lap_class_o    = lap_class_q;
  assign best_ms_o      = best_q;
  assign status_o       = status_q;

  `LAPT_ASSERT_NEXT(a_best_never_grows, 1'b1, best_q <= $past(best_q), "best lap grew")
  `LAPT_ASSERT_IMPL(a_class_needs_sound, valid_q && (lap_class_q != CLS_NONE), (status_q == ST_OK) && sound_q, "lap classified without sound or with error")
  `LAPT_ASSERT_IMPL(a_full_is_silent, valid_q && (status_q == ST_FULL), (lap_ms_q == '0) && (lap_class_q == CLS_NONE), "dropped crossing reported a lap")
  `LAPT_ASSERT_NEXT(a_single_strobe, valid_q, !valid_q, "result strobe lasted two cycles")

endmodule

`default_nettype wire

>>> design/multi_receiver_lap_time_recorder.sv
// Channel   Direction  Handshake                    Payload
// command   in         start / busy                 opcode_i, receiver_i, time_ms_i, lap_index_i
// result    out        result_valid_o (one cycle)   lap_count_o, lap_ms_o, lap_class_o,
//                                                   best_ms_o, status_o
// config    in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// After reset the timestamp RAM is cleared, one entry per cycle, all RECEIVERS*LAPS entries
// (512 by default) with busy high. A crossing or read item passes decode, RAM read and calc
// with busy high; its result strobe comes back in idle, which can already accept the next
// command. A dropped crossing, a bad receiver or lap index or an unknown opcode skips the RAM
// reads; a race start writes one RAM entry per cleared receiver. The result strobe cannot be
// stalled; cfg_ready_o is always high and configuration is taken at any time.
`default_nettype none

module multi_receiver_lap_time_recorder import lapt_pkg::*; #(
  parameter int unsigned RECEIVERS = RECEIVERS_DEF,
  parameter int unsigned LAPS      = LAPS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OPCODE_W-1:0]   opcode_i,
  input  wire logic [RX_W-1:0]       receiver_i,
  input  wire logic [TIME_W-1:0]     time_ms_i,
  input  wire logic [LAP_IDX_W-1:0]  lap_index_i,
  output logic                       result_valid_o,
  output logic      [COUNT_W-1:0]    lap_count_o,
  output logic      [TIME_W-1:0]     lap_ms_o,
  output logic      [CLASS_W-1:0]    lap_class_o,
  output logic      [TIME_W-1:0]     best_ms_o,
  output logic      [STATUS_W-1:0]   status_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(RECEIVERS * LAPS);

  lapt_cmd_t         cmd;
  lapt_sts_t         sts;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [TIME_W-1:0] ram_wdata, ram_rdata;

  lapt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lapt_dp #(
    .RECEIVERS (RECEIVERS),
    .LAPS      (LAPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .receiver_i     (receiver_i),
    .time_ms_i      (time_ms_i),
    .lap_index_i    (lap_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .result_valid_o (result_valid_o),
    .lap_count_o    (lap_count_o),
    .lap_ms_o       (lap_ms_o),
    .lap_class_o    (lap_class_o),
    .best_ms_o      (best_ms_o),
    .status_o       (status_o)
  );

  lapt_ram #(
    .WIDTH (TIME_W),
    .DEPTH (RECEIVERS * LAPS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench import lapt_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 175;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  ms;
    lap_class_e         cls;
    logic [TIME_W-1:0]  best;
    status_e            status;
  } lap_result_t;

  // Tracks the lap tables, counts, best lap and race start of the block and
  // holds the results still owed by it in order.
  class lap_scoreboard;
    logic [TIME_W-1:0]   stamp_q [RECEIVERS_DEF*LAPS_DEF];
    logic [COUNT_W-1:0]  count_q [RECEIVERS_DEF];
    logic [TIME_W-1:0]   best_q;
    logic [TIME_W-1:0]   race_start_q;
    logic [ACTIVE_W-1:0] active_rx_q;
    logic                sound_q;
    lap_result_t         owed_q[$];
    int                  errors;

    function new();
      foreach (stamp_q[i]) stamp_q[i] = '0;
      foreach (count_q[i]) count_q[i] = '0;
      best_q       = TIME_ALL_ONES;
      race_start_q = '0;
      active_rx_q  = ACTIVE_RESET;
      sound_q      = SOUND_RESET;
      errors       = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ACTIVE_RX) begin
        active_rx_q = data[ACTIVE_W-1:0];
      end else begin
        sound_q = data[0];
      end
    endfunction

    function void note_item(logic [OPCODE_W-1:0] op, logic [RX_W-1:0] rx,
                            logic [TIME_W-1:0] t, logic [LAP_IDX_W-1:0] lap);
      lap_result_t       r;
      int                base;
      int                n;
      int                c;
      logic [TIME_W-1:0] cur;
      logic [TIME_W-1:0] prev;
      base = int'(rx) * LAPS_DEF;
      r = '{count: '0, ms: '0, cls: CLS_NONE, best: '0, status: ST_OK};
      case (op)
        OP_START: begin
          n = (active_rx_q > RECEIVERS_DEF) ? RECEIVERS_DEF : int'(active_rx_q);
          for (int i = 0; i < n; i++) begin
            count_q[i] = '0;
            stamp_q[i*LAPS_DEF] = t;
          end
          race_start_q = t;
        end
        OP_CROSS: begin
          c = int'(count_q[rx]);
          if (c >= LAPS_DEF - 1) begin
            r.status = ST_FULL;
          end else begin
            cur  = t - stamp_q[base+c];
            prev = (c > 0) ? stamp_q[base+c] - stamp_q[base+c-1] : cur;
            if (cur < best_q) best_q = cur;
            count_q[rx] = COUNT_W'(c + 1);
            stamp_q[base+c+1] = t;
            r.ms = cur;
            if (sound_q) begin
              if (cur == best_q) begin
                r.cls = CLS_BEST;
              end else if (cur < prev) begin
                r.cls = CLS_FASTER;
              end else begin
                r.cls = CLS_SLOWER;
              end
            end
          end
        end
        OP_READ_ABS: r.ms = stamp_q[base+lap];
        OP_READ_DUR: begin
          if (lap == 0) begin
            r.ms = '0;
          end else if (lap == 1) begin
            r.ms = stamp_q[base+1] - race_start_q;
          end else begin
            r.ms = stamp_q[base+lap] - stamp_q[base+lap-1];
          end
        end
        OP_READ_SINCE: r.ms = stamp_q[base+lap] - race_start_q;
        default: ;
      endcase
      r.count = count_q[rx];
      r.best  = best_q;
      owed_q.push_back(r);
    endfunction

    function void check_result(lap_result_t got);
      lap_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: lap_count %0d lap_ms %0h", got.count, got.ms);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.count !== want.count) begin
        $error("lap_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
      if (got.ms !== want.ms) begin
        $error("lap_ms: expected %0h, actual %0h", want.ms, got.ms);
        errors++;
      end
      if (got.cls !== want.cls) begin
        $error("lap_class: expected %0d, actual %0d", want.cls, got.cls);
        errors++;
      end
      if (got.best !== want.best) begin
        $error("best_ms: expected %0h, actual %0h", want.best, got.best);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OPCODE_W-1:0]   opcode_i = '0;
  logic [RX_W-1:0]       receiver_i = '0;
  logic [TIME_W-1:0]     time_ms_i = '0;
  logic [LAP_IDX_W-1:0]  lap_index_i = '0;
  logic                  result_valid_o;
  logic [COUNT_W-1:0]    lap_count_o;
  logic [TIME_W-1:0]     lap_ms_o;
  logic [CLASS_W-1:0]    lap_class_o;
  logic [TIME_W-1:0]     best_ms_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lap_scoreboard lap_sb = new();
  int unsigned   cycle_count = 0;
  int unsigned   gap_pct = 0;
  int unsigned   phase_items;

  multi_receiver_lap_time_recorder u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        lap_sb.check_result('{lap_count_o, lap_ms_o, lap_class_e'(lap_class_o), best_ms_o,
                              status_e'(status_o)});
      end
      if (start && !busy) lap_sb.note_item(opcode_i, receiver_i, time_ms_i, lap_index_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer with start
  // still high, so the caller either presents the next item or drops start.
  task automatic send_item(int unsigned op, int unsigned rx, logic [TIME_W-1:0] t,
                           int unsigned lap);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start       = 1'b1;
    opcode_i    = OPCODE_W'(op);
    receiver_i  = RX_W'(rx);
    time_ms_i   = t;
    lap_index_i = LAP_IDX_W'(lap);
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    phase_items++;
  endtask

  task automatic send_crossing(int unsigned rx);
    int unsigned       pick;
    logic [TIME_W-1:0] last;
    last = lap_sb.stamp_q[rx*LAPS_DEF + lap_sb.count_q[rx]];
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_item(OP_CROSS, rx, last + $urandom_range(3), 0);
    end else if (pick < 8) begin
      send_item(OP_CROSS, rx, $urandom, $urandom_range(63));
    end else if (pick < 15) begin
      send_item(OP_CROSS, rx, last + $urandom_range(1 << 24), 0);
    end else begin
      send_item(OP_CROSS, rx, last + $urandom_range(5000, 1), 0);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (lap_sb.owed_q.size() != 0 || busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(int unsigned active_rx, int unsigned sound);
    cfg_valid_i = 1'b1;
    cfg_index_i = CFG_ACTIVE_RX;
    cfg_data_i  = CFG_DATA_W'(active_rx);
    do @(posedge clk_i); while (!cfg_ready_o);
    lap_sb.write_reg(CFG_ACTIVE_RX, cfg_data_i);
    @(negedge clk_i);
    cfg_index_i = CFG_SOUND;
    cfg_data_i  = CFG_DATA_W'(sound);
    do @(posedge clk_i); while (!cfg_ready_o);
    lap_sb.write_reg(CFG_SOUND, cfg_data_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_race(int unsigned len);
    int unsigned focus;
    int unsigned pick;
    int unsigned rx;
    send_item(OP_START, $urandom_range(7), $urandom, $urandom_range(63));
    focus = $urandom_range(7);
    for (int i = 0; (i < int'(len)) && (phase_items < PHASE_ITEMS); i++) begin
      pick = $urandom_range(99);
      rx   = $urandom_range(7);
      if (pick < 45) begin
        send_crossing(focus);
      end else if (pick < 60) begin
        send_crossing(rx);
      end else if (pick < 90) begin
        send_item($urandom_range(OP_READ_SINCE, OP_READ_ABS), rx, $urandom,
                  ($urandom_range(3) == 0) ? $urandom_range(63)
                                           : $urandom_range(lap_sb.count_q[rx]));
      end else if (pick < 95) begin
        send_item($urandom_range(7, 5), rx, $urandom, $urandom_range(63));
      end else begin
        send_item(OP_START, rx, $urandom, $urandom_range(63));
      end
    end
  endtask

  int unsigned phase_active [8] = '{8, 1, 3, 1, 5, 8, 2, 6};
  int unsigned phase_sound  [8] = '{1, 1, 0, 1, 1, 0, 1, 1};
  int unsigned phase_gap    [8] = '{0, 69, 0, 16, 69, 0, 16, 69};

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(OP_READ_ABS, 0, 32'h0, 0);
    send_item(OP_START, 0, 32'd100, 0);
    send_item(OP_CROSS, 0, 32'd1100, 0);
    send_item(OP_CROSS, 0, 32'd1600, 0);
    send_item(OP_CROSS, 0, 32'd1900, 0);
    send_item(OP_CROSS, 1, 32'd900, 0);
    send_item(OP_CROSS, 1, 32'd1500, 0);
    send_item(OP_CROSS, 1, 32'd2500, 0);
    send_item(OP_READ_DUR, 0, 32'h0, 0);
    send_item(OP_READ_DUR, 0, 32'h0, 1);
    send_item(OP_READ_DUR, 0, 32'h0, 2);
    send_item(OP_READ_SINCE, 0, 32'h0, 3);
    send_item(OP_READ_ABS, 0, TIME_ALL_ONES, 63);
    send_item(OP_CROSS, 7, TIME_ALL_ONES, 63);
    send_item(OP_CROSS, 7, 32'h0, 0);
    send_item(OP_READ_SINCE, 7, 32'h0, 1);
    send_item(5, 7, TIME_ALL_ONES, 63);
    send_item(6, 7, TIME_ALL_ONES, 63);
    send_item(7, 7, TIME_ALL_ONES, 63);
    send_item(OP_START, 5, TIME_ALL_ONES, 63);
    send_item(OP_CROSS, 2, 32'h10, 0);
    send_item(OP_READ_DUR, 2, 32'h0, 1);
    send_item(OP_READ_ABS, 6, 32'h0, 0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      set_config(phase_active[p], phase_sound[p]);
      gap_pct     = phase_gap[p];
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        run_race(($urandom_range(3) == 0) ? 150 : $urandom_range(120, 5));
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (lap_sb.errors == 0 && lap_sb.owed_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
